FILE: rtl/cmg_pkg.sv
// shared types, widths and tables for the calendar month grid
// no dependencies; imported by cmg_front, cmg_cells and calendar_month_grid
package cmg_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int CELL_W  = 6;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int SUM_W   = 15;   // year + 400 and the weekday sum fit here

    localparam int GRID_CELLS = 42;
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(GRID_CELLS - 1);

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] MONTH_DAYS [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // per-month result handed from the date math to the cell generator
    typedef struct packed {
        logic [SUM_W-1:0] wday_sum;
        logic [DAY_W-1:0] month_length;
        logic             month_error;
    } t_month_info;

    function automatic logic [DAY_W-1:0] days_in_month(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [MONTH_W-1:0] idx;
        logic [DAY_W-1:0]   days;
        idx = month - 4'd1;
        if (month < MONTH_JAN || month > MONTH_DEC) begin
            days = '0;
        end else if (month == MONTH_FEB) begin
            days = leap ? 5'd29 : 5'd28;
        end else begin
            days = MONTH_DAYS[idx];
        end
        return days;
    endfunction

endpackage

FILE: rtl/calendar_month_grid.sv
// top level of the gregorian month calendar grid
// depends on cmg_pkg, cmg_front and cmg_cells
//
// input channel: i_valid / o_stall carry one transaction of i_year and i_month
// output channel: o_valid / i_stall carry one grid cell per transaction,
//   GRID_CELLS (42) cells per request in row-major order, sunday first;
//   o_last_cell marks the final cell of each request
// the first cell of a request reaches o_valid through the input register,
//   the divide-by-100 stage, the weekday sum stage, the cell generator
//   load and the output register
// throughput: one cell per cycle while i_stall is low; the cell
//   generator and its output register set this figure
// requests queue in the three date math stages while a grid is still being
//   sent, so a new request is taken while the previous grid drains
// reset (i_rst_n low at a clock edge) empties every stage; no request
//   in flight survives it
// when the receiver raises i_stall the output register holds its cell, the
//   cell generator waits, and the stall backs up into o_stall once the date
//   math stages are full
// an invalid month gives an all-blank grid with o_month_error set
module calendar_month_grid import cmg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CELL_W-1:0]  o_cell_index,
    output logic [DAY_W-1:0]   o_day_number,
    output logic [WDAY_W-1:0]  o_first_weekday,
    output logic [DAY_W-1:0]   o_month_length,
    output logic               o_month_error,
    output logic               o_last_cell
);

    // handoff between date math and the cell generator
    logic        info_valid;
    logic        info_ready;
    t_month_info info;

    cmg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_year       (i_year),
        .i_month      (i_month),
        .o_info_valid (info_valid),
        .i_info_ready (info_ready),
        .o_info       (info)
    );

    cmg_cells u_cells (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_info_valid    (info_valid),
        .o_info_ready    (info_ready),
        .i_info          (info),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cell_index    (o_cell_index),
        .o_day_number    (o_day_number),
        .o_first_weekday (o_first_weekday),
        .o_month_length  (o_month_length),
        .o_month_error   (o_month_error),
        .o_last_cell     (o_last_cell)
    );

endmodule

FILE: rtl/cmg_front.sv
// date math pipeline: input register, divide-by-100 stage, weekday sum stage
// depends on cmg_pkg
module cmg_front import cmg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    output logic               o_info_valid,
    input  logic               i_info_ready,
    output t_month_info        o_info
);

    localparam logic [SUM_W-1:0] YEAR_SHIFT = 15'd400;
    localparam int               PROD_W     = SUM_W + 13;
    localparam logic [PROD_W-1:0] RECIP_100 = 28'd5243;
    localparam int               RECIP_SH   = 19;
    localparam int               Q_W        = PROD_W - RECIP_SH;

    // month term (13m-1)/5 with march as month 1
    function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] mm);
        logic [DAY_W-1:0] t;
        unique case (mm)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd18;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd31;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    logic               r1_v, r2_v, r3_v;
    logic               free1, free2, free3;

    logic [YEAR_W-1:0]  r1_year;
    logic [MONTH_W-1:0] r1_month;

    logic [SUM_W-1:0]   r2_yp;
    logic [Q_W-1:0]     r2_qp;
    logic               r2_dec;
    logic [MONTH_W-1:0] r2_mm;
    logic [MONTH_W-1:0] r2_month;

    t_month_info        r3_info;

    // stage 2 logic
    logic [SUM_W-1:0]   n_yp;
    logic [PROD_W-1:0]  prod;
    logic               n_dec;
    logic [MONTH_W-1:0] n_mm;

    // stage 3 logic
    logic [SUM_W+1:0]   qp_x100;
    logic               rem_zero;
    logic               leap;
    logic [SUM_W-1:0]   yy;
    logic [Q_W-1:0]     q100;
    logic [SUM_W-1:0]   n_sum;
    t_month_info        n_info;

    assign free3   = !r3_v || i_info_ready;
    assign free2   = !r2_v || free3;
    assign free1   = !r1_v || free2;
    assign o_stall = !free1;

    assign n_yp  = SUM_W'(r1_year) + YEAR_SHIFT;
    assign prod  = PROD_W'(n_yp) * RECIP_100;
    assign n_dec = (r1_month <= MONTH_FEB);
    assign n_mm  = n_dec ? (r1_month + 4'd10) : (r1_month - 4'd2);

    assign qp_x100  = (SUM_W+2)'(r2_qp) * (SUM_W+2)'(100);
    assign rem_zero = (qp_x100 == (SUM_W+2)'(r2_yp));
    assign leap     = (r2_yp[1:0] == 2'b00) && (!rem_zero || r2_qp[1:0] == 2'b00);
    assign yy       = r2_yp - SUM_W'(r2_dec);
    assign q100     = r2_qp - Q_W'(r2_dec && rem_zero);
    assign n_sum    = yy + (yy >> 2) + SUM_W'(q100 >> 2) - SUM_W'(q100)
                    + SUM_W'(month_term(r2_mm)) + SUM_W'(1);

    always_comb begin
        n_info.wday_sum     = n_sum;
        n_info.month_length = days_in_month(r2_month, leap);
        n_info.month_error  = (r2_month < MONTH_JAN) || (r2_month > MONTH_DEC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (free1) begin
                r1_v <= i_valid;
            end
            if (free2) begin
                r2_v <= r1_v;
            end
            if (free3) begin
                r3_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free1 && i_valid) begin
            r1_year  <= i_year;
            r1_month <= i_month;
        end
        if (free2 && r1_v) begin
            r2_yp    <= n_yp;
            r2_qp    <= prod[PROD_W-1:RECIP_SH];
            r2_dec   <= n_dec;
            r2_mm    <= n_mm;
            r2_month <= r1_month;
        end
        if (free3 && r2_v) begin
            r3_info <= n_info;
        end
    end

    assign o_info_valid = r3_v;
    assign o_info       = r3_info;

endmodule

FILE: rtl/cmg_cells.sv
// grid cell generator: walks the cells of one month into the output register
// depends on cmg_pkg
module cmg_cells import cmg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_info_valid,
    output logic               o_info_ready,
    input  t_month_info        i_info,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CELL_W-1:0]  o_cell_index,
    output logic [DAY_W-1:0]   o_day_number,
    output logic [WDAY_W-1:0]  o_first_weekday,
    output logic [DAY_W-1:0]   o_month_length,
    output logic               o_month_error,
    output logic               o_last_cell
);

    // modulo 7 by folding octal digits, since 8 is 1 mod 7
    function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] s);
        logic [5:0] f1;
        logic [3:0] f2;
        logic [3:0] f3;
        f1 = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
        f2 = 4'(f1[2:0]) + 4'(f1[5:3]);
        f3 = 4'(f2[2:0]) + 4'(f2[3]);
        return (f3 == 4'd7) ? 3'd0 : f3[2:0];
    endfunction

    logic               r_busy;
    logic [CELL_W-1:0]  r_idx;
    logic [WDAY_W-1:0]  r_first;
    logic [DAY_W-1:0]   r_len;
    logic               r_err;

    logic               r_ov;
    logic [CELL_W-1:0]  r_out_idx;
    logic [DAY_W-1:0]   r_out_day;
    logic [WDAY_W-1:0]  r_out_first;
    logic [DAY_W-1:0]   r_out_len;
    logic               r_out_err;
    logic               r_out_last;

    logic               out_free;
    logic               emit;
    logic               at_last;
    logic               load;
    logic [CELL_W-1:0]  offset;
    logic               in_month;
    logic [DAY_W-1:0]   n_day;

    assign out_free     = !r_ov || !i_stall;
    assign emit         = r_busy && out_free;
    assign at_last      = (r_idx == LAST_CELL);
    assign o_info_ready = !r_busy || (emit && at_last);
    assign load         = i_info_valid && o_info_ready;

    assign offset   = r_idx - CELL_W'(r_first);
    assign in_month = !r_err && (r_idx >= CELL_W'(r_first))
                      && (offset < CELL_W'(r_len));
    assign n_day    = in_month ? (offset[DAY_W-1:0] + 5'd1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && at_last) begin
                r_busy <= 1'b0;
            end
            if (out_free) begin
                r_ov <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_idx   <= '0;
            r_first <= i_info.month_error ? '0 : mod7(i_info.wday_sum);
            r_len   <= i_info.month_length;
            r_err   <= i_info.month_error;
        end else if (emit) begin
            r_idx <= r_idx + 6'd1;
        end
        if (emit) begin
            r_out_idx   <= r_idx;
            r_out_day   <= n_day;
            r_out_first <= r_first;
            r_out_len   <= r_len;
            r_out_err   <= r_err;
            r_out_last  <= at_last;
        end
    end

    assign o_valid         = r_ov;
    assign o_cell_index    = r_out_idx;
    assign o_day_number    = r_out_day;
    assign o_first_weekday = r_out_first;
    assign o_month_length  = r_out_len;
    assign o_month_error   = r_out_err;
    assign o_last_cell     = r_out_last;

endmodule
